// ----- rtl/cst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg
// Types, codes and helpers shared by the connection slot table.
// ----------------------------------------------------------------------------
package cst_pkg;

   localparam int SLOT_COUNT_DEF = 8;

   localparam logic [15:0] HANDLE_INVALID = 16'hFFFF;
   localparam logic [3:0]  ACTIVE_RESET   = 4'd8;
   localparam logic [15:0] SLICE_RESET    = 16'd0;
   localparam logic [3:0]  MAX_RESULTS    = 4'd8;

   localparam logic CSR_ACTIVE_SLOTS = 1'b0;
   localparam logic CSR_SLICE_SIZE   = 1'b1;

   localparam logic [1:0] ROLE_CENTRAL    = 2'd0;
   localparam logic [1:0] ROLE_PERIPHERAL = 2'd1;
   localparam logic [1:0] ROLE_UNKNOWN    = 2'd2;

   typedef enum logic [2:0] {
      FUNC_CONNECT = 3'd0,
      FUNC_FREE    = 3'd1,
      FUNC_LOOKUP  = 3'd2,
      FUNC_ROLE    = 3'd3,
      FUNC_LIST    = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_NEW       = 3'd0,
      ST_EXISTING  = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_INVALID   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH,
      S_REPLY,
      S_LIST_END
   } state_type;

   typedef struct packed {
      logic [15:0] handle;
      logic [7:0]  role;
      logic [7:0]  peer_type;
      logic [47:0] peer_address;
      logic [7:0]  own_type;
      logic [47:0] own_address;
   } entry_type;

   typedef struct packed {
      logic wr;
      logic clr;
   } store_cmd_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  slot_index;
      logic [1:0]  role;
      logic [15:0] handle;
      logic [7:0]  peer_type;
      logic [47:0] peer_address;
      logic [7:0]  own_type;
      logic [47:0] own_address;
      logic [18:0] offset;
      logic        last;
   } result_type;

   function automatic logic [1:0] map_role(input logic [7:0] r);
      logic [1:0] m;
      if (r == 8'd0) begin
         m = ROLE_CENTRAL;
      end else if (r == 8'd1) begin
         m = ROLE_PERIPHERAL;
      end else begin
         m = ROLE_UNKNOWN;
      end
      return m;
   endfunction

   function automatic result_type none_result(input status_type st);
      result_type r;
      r.status       = st;
      r.slot_index   = 3'd0;
      r.role         = ROLE_UNKNOWN;
      r.handle       = HANDLE_INVALID;
      r.peer_type    = 8'd0;
      r.peer_address = 48'd0;
      r.own_type     = 8'd0;
      r.own_address  = 48'd0;
      r.offset       = 19'd0;
      r.last         = 1'b1;
      return r;
   endfunction

   function automatic result_type slot_result(input status_type st, input logic [2:0] idx,
                                              input entry_type e, input logic [18:0] off);
      result_type r;
      r.status       = st;
      r.slot_index   = idx;
      r.role         = map_role(e.role);
      r.handle       = e.handle;
      r.peer_type    = e.peer_type;
      r.peer_address = e.peer_address;
      r.own_type     = e.own_type;
      r.own_address  = e.own_address;
      r.offset       = off;
      r.last         = 1'b1;
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/cst_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_store
// Slot memory with one write and one registered read port; per-slot valid
// flags cleared by reset, and the any-link flag over the active slots.
// ----------------------------------------------------------------------------
module cst_store
   import cst_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
   parameter int CNT_W      = $clog2(SLOT_COUNT + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CNT_W-1:0] n_act,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output entry_type             rd_data,
   output logic                  rd_hit,
   input  wire store_cmd_type    cmd,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire entry_type        wr_data,
   output logic                  any_connected
);

   entry_type             mem [SLOT_COUNT];
   entry_type             rd_data_ff;
   logic                  rd_hit_ff;
   logic [SLOT_COUNT-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
         if (cmd.wr) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (cmd.clr) begin
            valid_ff[wr_addr] <= 1'b0;
         end
      end
   end

   always_comb begin
      any_connected = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (valid_ff[i] && (CNT_W'(i) < n_act)) begin
            any_connected = 1'b1;
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_hit  = rd_hit_ff;

endmodule
`default_nettype wire

// ----- rtl/cst_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_ctrl
// Request sequencer: walks the active slots one a cycle through the store's
// read port and a single handle comparator, then updates the slot for connect
// and free and forms the results; list results are formed during the walk.
// ----------------------------------------------------------------------------
module cst_ctrl
   import cst_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
   parameter int CNT_W      = $clog2(SLOT_COUNT + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [2:0]       req_func,
   input  wire logic [15:0]      req_conn_handle,
   input  wire logic [7:0]       req_role_in,
   input  wire logic [7:0]       req_peer_type_in,
   input  wire logic [47:0]      req_peer_address_in,
   input  wire logic [7:0]       req_own_type_in,
   input  wire logic [47:0]      req_own_address_in,
   input  wire logic [3:0]       req_max_count,
   input  wire logic [CNT_W-1:0] n_act,
   input  wire logic [15:0]      slice,
   output logic                  rd_en,
   output logic [IDX_W-1:0]      rd_addr,
   input  wire entry_type        rd_data,
   input  wire logic             rd_hit,
   output store_cmd_type         cmd,
   output logic [IDX_W-1:0]      wr_addr,
   output entry_type             wr_data,
   input  wire logic             any_connected,
   output logic                  rsp_strobe,
   output result_type            rsp,
   output logic                  rsp_any
);

   state_type        state_ff, state_in;
   func_type         func_ff, func_in;
   entry_type        req_ff, req_in;
   logic [3:0]       lim_ff, lim_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [18:0]      rd_off_ff, rd_off_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_ptr_ff, cmp_ptr_in;
   logic [18:0]      cmp_off_ff, cmp_off_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;
   logic [18:0]      found_off_ff, found_off_in;
   entry_type        found_ent_ff, found_ent_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [18:0]      free_off_ff, free_off_in;
   logic [3:0]       cnt_ff, cnt_in;
   result_type       pend_ff, pend_in;
   logic             pend_vld_ff, pend_vld_in;
   result_type       res_ff, res_in;
   result_type       rsp_ff, rsp_in;
   logic             rsp_any_ff, rsp_any_in;
   logic             strobe_ff, strobe_in;

   logic             scan_done;
   logic             list_hit;
   logic             last_hit;
   logic             is_list;
   result_type       cand;
   logic [IDX_W-1:0] tgt_idx;
   logic [18:0]      tgt_off;

   assign is_list   = (func_ff == FUNC_LIST);
   assign scan_done = (rd_ptr_ff == n_act) && !cmp_vld_ff;
   assign list_hit  = (state_ff == S_SCAN) && is_list && cmp_vld_ff && rd_hit;
   assign last_hit  = list_hit && ((cnt_ff + 4'd1) == lim_ff);
   assign cand      = slot_result(ST_EXISTING, 3'(cmp_ptr_ff), rd_data, cmp_off_ff);
   assign tgt_idx   = found_ff ? found_idx_ff : free_idx_ff;
   assign tgt_off   = found_ff ? found_off_ff : free_off_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_func) inside
                  FUNC_LIST: begin
                     state_in = (req_max_count != 4'd0) ? S_SCAN : S_IDLE;
                  end
                  FUNC_CONNECT, FUNC_FREE, FUNC_LOOKUP, FUNC_ROLE: begin
                     state_in = (req_conn_handle == HANDLE_INVALID) ? S_REPLY : S_SCAN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (last_hit) begin
               state_in = S_LIST_END;
            end else if (scan_done) begin
               if (is_list) begin
                  state_in = pend_vld_ff ? S_LIST_END : S_IDLE;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH:   state_in = S_REPLY;
         S_REPLY:    state_in = S_IDLE;
         S_LIST_END: state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      func_in      = func_ff;
      req_in       = req_ff;
      lim_in       = lim_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_off_in    = rd_off_ff;
      cmp_vld_in   = 1'b0;
      cmp_ptr_in   = rd_ptr_ff[IDX_W-1:0];
      cmp_off_in   = rd_off_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      found_off_in = found_off_ff;
      found_ent_in = found_ent_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      free_off_in  = free_off_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_any_in   = rsp_any_ff;
      strobe_in    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = rd_ptr_ff[IDX_W-1:0];
      cmd          = '0;
      wr_addr      = tgt_idx;
      wr_data      = req_ff;

      unique case (state_ff)
         S_IDLE: begin
            func_in                = func_type'(req_func);
            req_in.handle          = req_conn_handle;
            req_in.role            = req_role_in;
            req_in.peer_type       = req_peer_type_in;
            req_in.peer_address    = req_peer_address_in;
            req_in.own_type        = req_own_type_in;
            req_in.own_address     = req_own_address_in;
            lim_in      = (req_max_count > MAX_RESULTS) ? MAX_RESULTS : req_max_count;
            rd_ptr_in   = '0;
            rd_off_in   = '0;
            found_in    = 1'b0;
            free_in     = 1'b0;
            cnt_in      = 4'd0;
            pend_vld_in = 1'b0;
            res_in      = none_result(ST_INVALID);
         end
         S_SCAN: begin
            if (rd_ptr_ff != n_act) begin
               rd_en      = 1'b1;
               rd_ptr_in  = rd_ptr_ff + CNT_W'(1);
               rd_off_in  = rd_off_ff + 19'(slice);
               cmp_vld_in = 1'b1;
            end
            if (is_list) begin
               if (list_hit) begin
                  if (pend_vld_ff) begin
                     rsp_in      = pend_ff;
                     rsp_in.last = 1'b0;
                     rsp_any_in  = any_connected;
                     strobe_in   = 1'b1;
                  end
                  pend_in     = cand;
                  pend_vld_in = 1'b1;
                  cnt_in      = cnt_ff + 4'd1;
               end
            end else if (cmp_vld_ff) begin
               if (rd_hit && !found_ff && (rd_data.handle == req_ff.handle)) begin
                  found_in     = 1'b1;
                  found_idx_in = cmp_ptr_ff;
                  found_off_in = cmp_off_ff;
                  found_ent_in = rd_data;
               end
               if (!rd_hit && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_ptr_ff;
                  free_off_in = cmp_off_ff;
               end
            end
         end
         S_FINISH: begin
            case (func_ff) inside
               FUNC_CONNECT: begin
                  if (found_ff || free_ff) begin
                     cmd.wr = 1'b1;
                     res_in = slot_result(status_type'(found_ff ? ST_EXISTING : ST_NEW),
                                          3'(tgt_idx), req_ff, tgt_off);
                  end else begin
                     res_in = none_result(ST_FULL);
                  end
               end
               FUNC_FREE: begin
                  wr_addr = found_idx_ff;
                  if (found_ff) begin
                     cmd.clr           = 1'b1;
                     res_in            = none_result(ST_EXISTING);
                     res_in.slot_index = 3'(found_idx_ff);
                  end else begin
                     res_in = none_result(ST_NOT_FOUND);
                  end
               end
               FUNC_LOOKUP, FUNC_ROLE: begin
                  if (found_ff) begin
                     res_in = slot_result(ST_EXISTING, 3'(found_idx_ff), found_ent_ff,
                                          found_off_ff);
                  end else begin
                     res_in = none_result(ST_NOT_FOUND);
                  end
               end
               default: res_in = none_result(ST_NOT_FOUND);
            endcase
         end
         S_REPLY: begin
            rsp_in     = res_ff;
            rsp_any_in = any_connected;
            strobe_in  = 1'b1;
         end
         S_LIST_END: begin
            rsp_in      = pend_ff;
            rsp_in.last = 1'b1;
            rsp_any_in  = any_connected;
            strobe_in   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cmp_vld_ff  <= 1'b0;
         strobe_ff   <= 1'b0;
         found_ff    <= 1'b0;
         free_ff     <= 1'b0;
         pend_vld_ff <= 1'b0;
         cnt_ff      <= 4'd0;
         rd_ptr_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         cmp_vld_ff  <= cmp_vld_in;
         strobe_ff   <= strobe_in;
         found_ff    <= found_in;
         free_ff     <= free_in;
         pend_vld_ff <= pend_vld_in;
         cnt_ff      <= cnt_in;
         rd_ptr_ff   <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      req_ff       <= req_in;
      lim_ff       <= lim_in;
      rd_off_ff    <= rd_off_in;
      cmp_ptr_ff   <= cmp_ptr_in;
      cmp_off_ff   <= cmp_off_in;
      found_idx_ff <= found_idx_in;
      found_off_ff <= found_off_in;
      found_ent_ff <= found_ent_in;
      free_idx_ff  <= free_idx_in;
      free_off_ff  <= free_off_in;
      pend_ff      <= pend_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
      rsp_any_ff   <= rsp_any_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;
   assign rsp_any    = rsp_any_ff;

endmodule
`default_nettype wire

// ----- rtl/connection_slot_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// connection_slot_table
// Table of link slots keyed by connection handle: connect, free, lookup,
// role query and handle listing, with long-write buffer offsets per slot.
//
//   channel   ports                      transfer
//   request   start, busy, req_*         start high while busy low
//   result    rsp_strobe, rsp_*          rsp_strobe high, one cycle each
//   csr       csr_we, csr_index, csr_*   csr_we high, no wait
//
// Request walks the active slots (n) one per cycle through the slot memory
// read port and one handle comparator. Connect, free, lookup, role query:
// walk, finish step (slot written or freed for connect/free), reply step.
// Invalid handle: reply step only. List: results stream during the walk,
// the last one flagged; a zero limit or no valid slot gives none. Reset
// clears valid flags together, no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module connection_slot_table
   import cst_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_func,
   input  wire logic [15:0] req_conn_handle,
   input  wire logic [7:0]  req_role_in,
   input  wire logic [7:0]  req_peer_type_in,
   input  wire logic [47:0] req_peer_address_in,
   input  wire logic [7:0]  req_own_type_in,
   input  wire logic [47:0] req_own_address_in,
   input  wire logic [3:0]  req_max_count,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [2:0]       rsp_slot_index,
   output logic [1:0]       rsp_role_out,
   output logic [15:0]      rsp_handle_out,
   output logic [7:0]       rsp_peer_type_out,
   output logic [47:0]      rsp_peer_address_out,
   output logic [7:0]       rsp_own_type_out,
   output logic [47:0]      rsp_own_address_out,
   output logic [18:0]      rsp_buffer_offset,
   output logic             rsp_any_connected,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

   logic [3:0]       active_ff;
   logic [15:0]      slice_ff;
   logic [CNT_W-1:0] n_act;
   logic [CMP_W-1:0] active_w;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   logic             rd_hit;
   store_cmd_type    cmd;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             any_connected;
   result_type       rsp;
   logic             rsp_any;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         slice_ff  <= SLICE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACTIVE_SLOTS: active_ff <= csr_wdata[3:0];
            CSR_SLICE_SIZE:   slice_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign active_w = CMP_W'(active_ff);
   assign n_act    = (active_w > CMP_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT) : CNT_W'(active_w);

   cst_store #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_store (
      .clock         (clock),
      .reset         (reset),
      .n_act         (n_act),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .rd_hit        (rd_hit),
      .cmd           (cmd),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .any_connected (any_connected)
   );

   cst_ctrl #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_conn_handle     (req_conn_handle),
      .req_role_in         (req_role_in),
      .req_peer_type_in    (req_peer_type_in),
      .req_peer_address_in (req_peer_address_in),
      .req_own_type_in     (req_own_type_in),
      .req_own_address_in  (req_own_address_in),
      .req_max_count       (req_max_count),
      .n_act               (n_act),
      .slice               (slice_ff),
      .rd_en               (rd_en),
      .rd_addr             (rd_addr),
      .rd_data             (rd_data),
      .rd_hit              (rd_hit),
      .cmd                 (cmd),
      .wr_addr             (wr_addr),
      .wr_data             (wr_data),
      .any_connected       (any_connected),
      .rsp_strobe          (rsp_strobe),
      .rsp                 (rsp),
      .rsp_any             (rsp_any)
   );

   assign rsp_status           = rsp.status;
   assign rsp_slot_index       = rsp.slot_index;
   assign rsp_role_out         = rsp.role;
   assign rsp_handle_out       = rsp.handle;
   assign rsp_peer_type_out    = rsp.peer_type;
   assign rsp_peer_address_out = rsp.peer_address;
   assign rsp_own_type_out     = rsp.own_type;
   assign rsp_own_address_out  = rsp.own_address;
   assign rsp_buffer_offset    = rsp.offset;
   assign rsp_any_connected    = rsp_any;
   assign rsp_last             = rsp.last;

endmodule
`default_nettype wire
